// ----- rtl/cwpd_pkg.sv -----
// Shared widths, register indexes, reset values and pixel types of the cross-window dilation.
package cwpd_pkg;

    localparam int CH_W       = 8;
    localparam int RGB_W      = 3 * CH_W;
    localparam int PIX_W      = 4 * CH_W;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RGB_W;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [RGB_W-1:0] rgb_t;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1;
    localparam rgb_t                BG_RESET     = 24'd0;

endpackage

// ----- rtl/cross_window_pixel_dilation.sv -----
// Top level of the cross-window RGBA dilation over a raster pixel stream.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_in_red, s_in_green, s_in_blue, s_in_alpha
//  m_       out        m_valid/m_ready    m_out_red, m_out_green, m_out_blue, m_out_alpha,
//                                         m_end_of_image
//  cfg_     in         cfg_wr_en          cfg_index, cfg_data
//
// One item is accepted per cycle while s_ready is high; a result is registered and shows
// in the next cycle. Both line banks are read ahead at the next item's column through
// their registered read ports, so the read data is ready when that item is accepted.
// Each configuration write holds s_ready low for one cycle while the left neighbor is refetched.
// Reset clears the counters, the bank select and the output valid; the banks need no clearing.
// A stalled output holds s_ready low only for items that produce a result.
module cross_window_pixel_dilation
    import cwpd_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CH_W-1:0]       s_in_red,
    input  logic [CH_W-1:0]       s_in_green,
    input  logic [CH_W-1:0]       s_in_blue,
    input  logic [CH_W-1:0]       s_in_alpha,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_out_red,
    output logic [CH_W-1:0]       m_out_green,
    output logic [CH_W-1:0]       m_out_blue,
    output logic [CH_W-1:0]       m_out_alpha,
    output logic                  m_end_of_image
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int MWW = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (MWW > WIDTH_W) ? MWW : WIDTH_W;

    function automatic logic [WW-1:0] eff_width(input logic [WIDTH_W-1:0] wr);
        logic [WW-1:0] x;
        x = WW'(wr);
        if (x == '0) begin
            return WW'(1);
        end else if (x > WW'(MAX_WIDTH)) begin
            return WW'(MAX_WIDTH);
        end
        return x;
    endfunction

    function automatic logic [AW-1:0] clamp_col(input logic [AW-1:0] cnt,
                                                 input logic [WW-1:0] w);
        logic [WW-1:0] c;
        c = WW'(cnt);
        if (c >= w) begin
            c = w - WW'(1);
        end
        return c[AW-1:0];
    endfunction

    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    rgb_t                bg_reg, bg_next;
    logic [AW-1:0]       column_count_reg, column_count_next;
    logic [HEIGHT_W-1:0] row_count_reg, row_count_next;
    logic                bank_select_reg, bank_select_next;
    logic                fix_reg;
    pix_t                left_reg;
    logic                m_valid_reg;
    pix_t                out_pix_reg;
    logic                out_eoi_reg;

    logic [WW-1:0]       w_cur, w_nxt;
    logic [AW-1:0]       col, col_nxt;
    logic [HEIGHT_W-1:0] h_cur;
    logic                flush, last_col, produce, accept;
    pix_t                cur;
    logic [AW-1:0]       rd0_addr, rd1_addr;
    pix_t                a_rd0, a_rd1, b_rd0, b_rd1;
    pix_t                prev_c, prev_r, up;
    pix_t                cand [5];
    logic [4:0]          cand_ok;
    pix_t                pick;
    logic                found;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        bg_next     = bg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                CFG_BG_COLOR:     bg_next     = cfg_data[RGB_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
    end

    assign w_cur    = eff_width(width_reg);
    assign col      = clamp_col(column_count_reg, w_cur);
    assign last_col = (WW'(col) == (w_cur - WW'(1)));
    assign h_cur    = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    assign flush    = (row_count_reg >= h_cur);
    assign produce  = (row_count_reg != '0);
    assign cur      = {s_in_red, s_in_green, s_in_blue, s_in_alpha};

    assign s_ready = !fix_reg && (!m_valid_reg || m_ready || !produce);
    assign accept  = s_valid && s_ready;

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        bank_select_next  = bank_select_reg;
        if (accept) begin
            if (last_col) begin
                column_count_next = '0;
                if (flush) begin
                    row_count_next   = '0;
                    bank_select_next = 1'b0;
                end else begin
                    row_count_next   = row_count_reg + HEIGHT_W'(1);
                    bank_select_next = !bank_select_reg;
                end
            end else begin
                column_count_next = col + AW'(1);
            end
        end
    end

    // Reads are issued for the state that holds after this edge.
    assign w_nxt    = eff_width(width_next);
    assign col_nxt  = clamp_col(column_count_next, w_nxt);
    assign rd0_addr = col_nxt;
    assign rd1_addr = cfg_wr_en ? (col_nxt - AW'(1)) : (col_nxt + AW'(1));

    cwpd_line_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (AW)
    ) u_bank_a (
        .aclk     (aclk),
        .wr_en    (accept && bank_select_reg),
        .wr_addr  (col),
        .wr_data  (cur),
        .rd0_addr (rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (a_rd0),
        .rd1_data (a_rd1)
    );

    cwpd_line_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (AW)
    ) u_bank_b (
        .aclk     (aclk),
        .wr_en    (accept && !bank_select_reg),
        .wr_addr  (col),
        .wr_data  (cur),
        .rd0_addr (rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (b_rd0),
        .rd1_data (b_rd1)
    );

    assign prev_c = bank_select_reg ? b_rd0 : a_rd0;
    assign prev_r = bank_select_reg ? b_rd1 : a_rd1;
    assign up     = bank_select_reg ? a_rd0 : b_rd0;

    always_comb begin
        cand[0]    = up;
        cand[1]    = left_reg;
        cand[2]    = prev_c;
        cand[3]    = prev_r;
        cand[4]    = cur;
        cand_ok[0] = (row_count_reg >= HEIGHT_W'(2));
        cand_ok[1] = (col != '0);
        cand_ok[2] = 1'b1;
        cand_ok[3] = !last_col;
        cand_ok[4] = !flush;
        pick  = '0;
        found = 1'b0;
        for (int k = 0; k < 5; k++) begin
            if (cand_ok[k] && !found) begin
                pick = cand[k];
                if (cand[k][PIX_W-1:CH_W] != bg_reg) begin
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            pick = {bg_reg, pick[CH_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg        <= WIDTH_RESET;
            height_reg       <= HEIGHT_RESET;
            bg_reg           <= BG_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            bank_select_reg  <= 1'b0;
            fix_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            width_reg        <= width_next;
            height_reg       <= height_next;
            bg_reg           <= bg_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            bank_select_reg  <= bank_select_next;
            fix_reg          <= cfg_wr_en;
            if (accept && produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg <= prev_c;
        end else if (fix_reg) begin
            left_reg <= prev_r;
        end
        if (accept && produce) begin
            out_pix_reg <= pick;
            out_eoi_reg <= flush && last_col;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_red      = out_pix_reg[4*CH_W-1:3*CH_W];
    assign m_out_green    = out_pix_reg[3*CH_W-1:2*CH_W];
    assign m_out_blue     = out_pix_reg[2*CH_W-1:CH_W];
    assign m_out_alpha    = out_pix_reg[CH_W-1:0];
    assign m_end_of_image = out_eoi_reg;

endmodule

// ----- rtl/cwpd_line_ram.sv -----
// Line bank memory with one write port and two registered read ports, write-first on a collision.
module cwpd_line_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd0_addr,
    input  logic [ADDR_W-1:0] rd1_addr,
    output logic [DATA_W-1:0] rd0_data,
    output logic [DATA_W-1:0] rd1_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd0_addr)) begin
            rd0_data <= wr_data;
        end else begin
            rd0_data <= mem[rd0_addr];
        end
        if (wr_en && (wr_addr == rd1_addr)) begin
            rd1_data <= wr_data;
        end else begin
            rd1_data <= mem[rd1_addr];
        end
    end

endmodule

// ----- rtl/cwpd_checker.sv -----
// Port-level checker for the cross-window dilation and its bind to the top level.
module cwpd_checker
    import cwpd_pkg::*;
(
    input logic            aclk,
    input logic            aresetn,
    input logic            cfg_wr_en,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input logic [CH_W-1:0] m_out_red,
    input logic [CH_W-1:0] m_out_green,
    input logic [CH_W-1:0] m_out_blue,
    input logic [CH_W-1:0] m_out_alpha,
    input logic            m_end_of_image
);

    // A result that waits keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_out_green)
            && $stable(m_out_blue) && $stable(m_out_alpha) && $stable(m_end_of_image))
    else $error("output item changed while stalled");

    // A new result always follows an accepted input item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
    else $error("output item without an accepted input item");

    // The cycle after a register write is spent refetching the left neighbor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
    else $error("input accepted during the refetch cycle");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("output valid after reset");

endmodule

bind cross_window_pixel_dilation cwpd_checker u_cwpd_checker (.*);
